// ----- rtl/core/magl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magl_pkg: shared definitions for the mono antiphase gearbox lowpass
// Widths, fixed-point formats, register map and sequencer state codes.
// ----------------------------------------------------------------------------
package magl_pkg;

  // Sample and state formats.
  localparam int SAMPLE_BITS     = 24;
  localparam int STATE_FRAC_BITS = 8;
  localparam int STATE_BITS      = 32;
  localparam int SUM_BITS        = SAMPLE_BITS + 1;
  localparam int MONO_BITS       = SUM_BITS + STATE_FRAC_BITS + 1;
  localparam int ROUND_HALF      = (1 << STATE_FRAC_BITS) >> 1;

  // Q16 coefficients.
  localparam int COEF_BITS   = 17;
  localparam int WEIGHT_BITS = 16;
  localparam logic [COEF_BITS-1:0] COEF_ONE    = 17'h10000;
  localparam logic [WEIGHT_BITS-1:0] CHASE_RESET = 16'd15007;
  localparam int Q16_ROUND = 32768;

  // Shared multiplier: signed 33 x 18.
  localparam int MUL_A_BITS = STATE_BITS + 1;
  localparam int MUL_B_BITS = COEF_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS   = PROD_BITS + 1;

  // Pole bank.
  localparam int NUM_POLES = 6;
  localparam int POLE_IDX_BITS = 3;
  localparam int NUM_STEPS = 3;
  localparam int STEP_BITS = 2;
  localparam int PHASE_BITS = 3;
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd5;

  // Register map.
  localparam int PADDR_BITS = 3;
  localparam int DATA_BITS  = 32;
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_CHASE  = 1'b1;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_GMUL0 = 8'b00000010,
    S_GMUL1 = 8'b00000100,
    S_GACC  = 8'b00001000,
    S_PMUL0 = 8'b00010000,
    S_PMUL1 = 8'b00100000,
    S_PACC  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/mono_antiphase_gearbox_lowpass_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_antiphase_gearbox_lowpass_core
// Stereo to mono mix, gliding coefficient, geared three-pole lowpass cascade,
// antiphase stereo output.
// ----------------------------------------------------------------------------
// Each input transaction is averaged to mono and run through three of six
// one-pole lowpass states chosen by a six-step phase counter, after the Q16
// coefficient has glided one step toward its target. All eight products go
// through one shared signed 33x18 multiplier under a small sequencer: the
// glide runs through the states GMUL0, GMUL1 and GACC and each pole through
// PMUL0, PMUL1 and PACC; the result then goes through the OUT state into the
// output register, where OUT waits while that register holds an unaccepted
// result, and the sequencer returns to idle to take the next input. The output
// register holds one result, so the next sample is accepted while the previous result still waits.
module mono_antiphase_gearbox_lowpass_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [23:0] left_sample, [47:24] right_sample
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  // Configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [magl_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [magl_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [magl_pkg::DATA_BITS-1:0]  prdata,
  output logic                                 pready
);

  localparam int SB = magl_pkg::SAMPLE_BITS;
  localparam int ST = magl_pkg::STATE_BITS;

  // Configuration registers.
  logic [magl_pkg::COEF_BITS-1:0]   target_q;
  logic [magl_pkg::WEIGHT_BITS-1:0] chase_q;
  logic                             cfg_wr;
  logic [magl_pkg::COEF_BITS-1:0]   target_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign target_wr = (pwdata[magl_pkg::COEF_BITS-1:0] > magl_pkg::COEF_ONE) ?
                     magl_pkg::COEF_ONE : pwdata[magl_pkg::COEF_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= magl_pkg::COEF_ONE;
      chase_q  <= magl_pkg::CHASE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        magl_pkg::REG_TARGET: target_q <= target_wr;
        magl_pkg::REG_CHASE:  chase_q  <= pwdata[magl_pkg::WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      magl_pkg::REG_TARGET: prdata = magl_pkg::DATA_BITS'(target_q);
      magl_pkg::REG_CHASE:  prdata = magl_pkg::DATA_BITS'(chase_q);
      default:              prdata = '0;
    endcase
  end

  // Sequencer and datapath state.
  magl_pkg::state_e state_q, state_d;
  logic [magl_pkg::COEF_BITS-1:0]     coef_q;
  logic [magl_pkg::PHASE_BITS-1:0]    phase_q;
  logic [magl_pkg::STEP_BITS-1:0]     step_q;
  logic signed [ST-1:0]               pole_q [magl_pkg::NUM_POLES];
  logic signed [ST-1:0]               x_q;
  logic signed [magl_pkg::PROD_BITS-1:0] prod_q;
  logic signed [magl_pkg::ACC_BITS-1:0]  acc_q;
  logic                               out_valid_q;
  logic [47:0]                        out_data_q;

  // Input mix: (left + right) in state format, halved with rounding.
  logic signed [SB-1:0]                     left_in, right_in;
  logic signed [magl_pkg::SUM_BITS-1:0]     mix_sum;
  logic signed [magl_pkg::MONO_BITS-1:0]    mono_wide;
  logic signed [ST-1:0]                     mono_sat;
  logic                                     in_fire;

  assign left_in  = s_axis_tdata[SB-1:0];
  assign right_in = s_axis_tdata[2*SB-1:SB];
  assign mix_sum  = magl_pkg::SUM_BITS'(left_in) + magl_pkg::SUM_BITS'(right_in);
  assign mono_wide = ((magl_pkg::MONO_BITS'(mix_sum) <<< magl_pkg::STATE_FRAC_BITS)
                     + magl_pkg::MONO_BITS'(1)) >>> 1;

  function automatic logic signed [ST-1:0] sat_state(
    input logic signed [magl_pkg::ACC_BITS-1:0] v
  );
    logic signed [magl_pkg::ACC_BITS-1:0] hi, lo;
    hi = magl_pkg::ACC_BITS'({1'b0, {(ST-1){1'b1}}});
    lo = -hi - magl_pkg::ACC_BITS'(1);
    if (v > hi) begin
      return hi[ST-1:0];
    end else if (v < lo) begin
      return lo[ST-1:0];
    end
    return v[ST-1:0];
  endfunction

  assign mono_sat = sat_state(magl_pkg::ACC_BITS'(mono_wide));

  assign s_axis_tready = (state_q == magl_pkg::S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Pole selection for the current cascade step.
  logic [magl_pkg::POLE_IDX_BITS-1:0] pole_idx;
  always_comb begin
    case (step_q)
      2'd0:    pole_idx = 3'd0;
      2'd1:    pole_idx = phase_q[0] ? 3'd2 : 3'd1;
      default: begin
        case (phase_q)
          3'd0, 3'd3: pole_idx = 3'd3;
          3'd1, 3'd4: pole_idx = 3'd4;
          default:    pole_idx = 3'd5;
        endcase
      end
    endcase
  end

  // Shared multiplier operand selection.
  logic signed [magl_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [magl_pkg::MUL_B_BITS-1:0] mul_b;
  logic [magl_pkg::COEF_BITS-1:0] keep_coef;
  logic [magl_pkg::COEF_BITS-1:0] keep_weight;

  assign keep_coef   = magl_pkg::COEF_ONE - coef_q;
  assign keep_weight = magl_pkg::COEF_ONE - magl_pkg::COEF_BITS'(chase_q);

  always_comb begin
    case (state_q)
      magl_pkg::S_GMUL0: begin
        mul_a = magl_pkg::MUL_A_BITS'(coef_q);
        mul_b = magl_pkg::MUL_B_BITS'(chase_q);
      end
      magl_pkg::S_GMUL1: begin
        mul_a = magl_pkg::MUL_A_BITS'(target_q);
        mul_b = magl_pkg::MUL_B_BITS'(keep_weight);
      end
      magl_pkg::S_PMUL0: begin
        mul_a = magl_pkg::MUL_A_BITS'(pole_q[pole_idx]);
        mul_b = magl_pkg::MUL_B_BITS'(keep_coef);
      end
      magl_pkg::S_PMUL1: begin
        mul_a = magl_pkg::MUL_A_BITS'(x_q);
        mul_b = magl_pkg::MUL_B_BITS'(coef_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Second product is summed with the rounded first one, then scaled by 2^-16.
  logic signed [magl_pkg::ACC_BITS-1:0] acc_sum;
  logic signed [magl_pkg::ACC_BITS-1:0] acc_scaled;
  logic [magl_pkg::COEF_BITS-1:0]       coef_new;
  logic signed [ST-1:0]                 pole_new;

  assign acc_sum    = acc_q + magl_pkg::ACC_BITS'(prod_q);
  assign acc_scaled = acc_sum >>> 16;
  assign coef_new   = (acc_scaled > magl_pkg::ACC_BITS'(magl_pkg::COEF_ONE)) ?
                      magl_pkg::COEF_ONE : acc_scaled[magl_pkg::COEF_BITS-1:0];
  assign pole_new   = sat_state(acc_scaled);

  // Output conversion: round state to sample format, saturate, negate.
  logic signed [ST:0]   out_round;
  logic signed [ST:0]   out_hi, out_lo;
  logic signed [SB-1:0] y_sat;
  logic signed [SB-1:0] y_neg;

  assign out_round = (ST+1)'(x_q) + (ST+1)'(magl_pkg::ROUND_HALF);
  assign out_hi    = (ST+1)'((out_round >>> magl_pkg::STATE_FRAC_BITS));
  assign out_lo    = (ST+1)'({1'b0, {(SB-1){1'b1}}});
  always_comb begin
    if (out_hi > out_lo) begin
      y_sat = out_lo[SB-1:0];
    end else if (out_hi < -out_lo - (ST+1)'(1)) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = out_hi[SB-1:0];
    end
    if (y_sat == {1'b1, {(SB-1){1'b0}}}) begin
      y_neg = {1'b0, {(SB-1){1'b1}}};
    end else begin
      y_neg = -y_sat;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      magl_pkg::S_IDLE:  if (in_fire) state_d = magl_pkg::S_GMUL0;
      magl_pkg::S_GMUL0: state_d = magl_pkg::S_GMUL1;
      magl_pkg::S_GMUL1: state_d = magl_pkg::S_GACC;
      magl_pkg::S_GACC:  state_d = magl_pkg::S_PMUL0;
      magl_pkg::S_PMUL0: state_d = magl_pkg::S_PMUL1;
      magl_pkg::S_PMUL1: state_d = magl_pkg::S_PACC;
      magl_pkg::S_PACC: begin
        if (step_q == magl_pkg::STEP_BITS'(magl_pkg::NUM_STEPS - 1)) begin
          state_d = magl_pkg::S_OUT;
        end else begin
          state_d = magl_pkg::S_PMUL0;
        end
      end
      magl_pkg::S_OUT: if (!out_valid_q || m_axis_tready) state_d = magl_pkg::S_IDLE;
      default: state_d = magl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= magl_pkg::S_IDLE;
      coef_q      <= magl_pkg::COEF_ONE;
      phase_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < magl_pkg::NUM_POLES; i++) begin
        pole_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // A new result may replace one that leaves in the same cycle.
      if (state_q == magl_pkg::S_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        magl_pkg::S_IDLE: begin
          if (in_fire) begin
            phase_q <= (phase_q >= magl_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;
            step_q  <= '0;
          end
        end
        magl_pkg::S_GACC: coef_q <= coef_new;
        magl_pkg::S_PACC: begin
          pole_q[pole_idx] <= pole_new;
          if (step_q == magl_pkg::STEP_BITS'(magl_pkg::NUM_STEPS - 1)) begin
            step_q <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      magl_pkg::S_IDLE: if (in_fire) x_q <= mono_sat;
      magl_pkg::S_GMUL1, magl_pkg::S_PMUL1: begin
        acc_q <= magl_pkg::ACC_BITS'(prod_q) + magl_pkg::ACC_BITS'(magl_pkg::Q16_ROUND);
      end
      magl_pkg::S_PACC: x_q <= pole_new;
      magl_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {y_sat, y_neg};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Assertions.
  a_coef_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_q <= magl_pkg::COEF_ONE)
    else $error("coefficient above one");

  a_target_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_q <= magl_pkg::COEF_ONE)
    else $error("target coefficient above one");

  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == magl_pkg::S_GMUL0)
    else $error("accepted sample did not start the glide");

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < magl_pkg::STEP_BITS'(magl_pkg::NUM_STEPS))
    else $error("cascade step out of range");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == magl_pkg::S_OUT))
    else $error("result appeared outside the output state");

endmodule
`default_nettype wire
